// File: rtl/mf3_pkg.sv
package mf3_pkg;

   // field widths
   localparam int PIX_W     = 8;
   localparam int X_W       = 11;
   localparam int Y_W       = 12;
   localparam int FW_W      = 12;
   localparam int FH_W      = 13;
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 1;

   // sizing defaults and limits
   localparam int DEF_MAX_WIDTH   = 2048;
   localparam int DEF_QUEUE_DEPTH = 4;
   localparam int MAX_HEIGHT      = 4096;

   // register reset values
   localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 12'd640;
   localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd480;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // input word actions
   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;
   // [0] lowest, [1] middle, [2] highest
   typedef logic [2:0][PIX_W-1:0] pix3_type;

   // one classified word handed from front to back
   typedef struct packed {
      logic            is_pix;
      logic            emit_a;
      logic            med_a;
      logic [X_W-1:0]  xa;
      logic [Y_W-1:0]  ya;
      logic            emit_b;
      logic [X_W-1:0]  xb;
      logic [Y_W-1:0]  yb;
      logic            fe;
      pix_type         pix;
      pix_type         line_a;
      pix_type         line_b;
   } job_type;

   // three-input compare-exchange sort
   function automatic pix3_type sort3(input pix_type a, input pix_type b, input pix_type c);
      pix_type  lo;
      pix_type  hi;
      pix3_type r;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c < lo) begin
         r = {hi, lo, c};
      end else if (c > hi) begin
         r = {c, hi, lo};
      end else begin
         r = {hi, c, lo};
      end
      return r;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      pix3_type s;
      s = sort3(a, b, c);
      return s[1];
   endfunction

   function automatic pix_type max3(input pix_type a, input pix_type b, input pix_type c);
      pix_type m;
      m = (a > b) ? a : b;
      return (c > m) ? c : m;
   endfunction

   function automatic pix_type min3(input pix_type a, input pix_type b, input pix_type c);
      pix_type m;
      m = (a < b) ? a : b;
      return (c < m) ? c : m;
   endfunction

endpackage

// File: rtl/mf3_ifs.sv
// pixel input channel
interface mf3_req_if;
   import mf3_pkg::*;
   logic             valid;
   logic             ready;
   logic             action;
   logic [PIX_W-1:0] pixel_in;
   modport source(output valid, action, pixel_in, input ready);
   modport sink(input valid, action, pixel_in, output ready);
endinterface

// filtered pixel output channel
interface mf3_rsp_if;
   import mf3_pkg::*;
   logic             valid;
   logic             ready;
   logic [X_W-1:0]   out_x;
   logic [Y_W-1:0]   out_y;
   logic [PIX_W-1:0] out_value;
   logic             frame_end;
   modport source(output valid, out_x, out_y, out_value, frame_end, input ready);
   modport sink(input valid, out_x, out_y, out_value, frame_end, output ready);
endinterface

// File: rtl/mf3_ram.sv
module mf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/mf3_queue.sv
module mf3_queue #(
   parameter int DEPTH = mf3_pkg::DEF_QUEUE_DEPTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int LW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  mf3_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output mf3_pkg::job_type pop_job,
   output logic [LW-1:0]    level
);
   import mf3_pkg::*;

   job_type       slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] count_ff, count_in;
   logic          do_pop;

   assign pop_valid = (count_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];
   assign do_pop    = pop_valid && pop_ready;
   assign level     = count_ff;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + LW'(push_valid) - LW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/mf3_front.sv
module mf3_front #(
   parameter int MAX_WIDTH   = mf3_pkg::DEF_MAX_WIDTH,
   parameter int QUEUE_DEPTH = mf3_pkg::DEF_QUEUE_DEPTH,
   localparam int LW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mf3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mf3_pkg::CSR_W-1:0]      csr_wdata,
   mf3_req_if.sink                        req,
   input  logic [LW-1:0]                  level,
   output logic                           push_valid,
   output mf3_pkg::job_type               push_job
);
   import mf3_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [CW-1:0]      col_ff, col_in;
   logic [CW-1:0]      flush_ff, flush_in;
   logic [Y_W-1:0]     row_ff, row_in;
   logic               flushing_ff, flushing_in;
   logic [FW_W-1:0]    fw_ff, fw_in;
   logic [FH_W-1:0]    fh_ff, fh_in;
   logic               f1_valid_ff, f1_valid_in;
   job_type            f1_job_ff, f1_job_in;
   logic [CW-1:0]      f1_addr_ff, f1_addr_in;
   logic [CW-1:0]      wlast;
   logic [Y_W-1:0]     hlast;
   logic               take, take_pix, take_flush;
   logic               end_row, last_flush;
   job_type            job;
   logic               ram_we;
   logic [2*PIX_W-1:0] ram_wdata, ram_rdata;

   // space for this word and the one already in flight
   assign req.ready  = (32'(level) + 32'(f1_valid_ff)) < QUEUE_DEPTH;
   assign take       = req.valid && req.ready;
   assign take_pix   = take && (req.action == ACT_PIXEL) && !flushing_ff;
   assign take_flush = take && (req.action == ACT_FLUSH) && flushing_ff;

   // last column and last row after saturation
   always_comb begin
      if (fw_ff < FW_W'(3)) begin
         wlast = CW'(2);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         wlast = CW'(MAX_WIDTH - 1);
      end else begin
         wlast = CW'(fw_ff - FW_W'(1));
      end
      if (fh_ff < FH_W'(3)) begin
         hlast = Y_W'(2);
      end else if (fh_ff > FH_W'(MAX_HEIGHT)) begin
         hlast = Y_W'(MAX_HEIGHT - 1);
      end else begin
         hlast = Y_W'(fh_ff - FH_W'(1));
      end
   end

   assign end_row    = (col_ff >= wlast);
   assign last_flush = (flush_ff >= wlast);

   // classify the word at the port
   always_comb begin
      job = '0;
      if (!flushing_ff) begin
         job.is_pix = 1'b1;
         job.emit_a = (row_ff != '0) && (col_ff != '0);
         job.med_a  = (row_ff >= Y_W'(2)) && (col_ff >= CW'(2));
         job.xa     = X_W'(col_ff - CW'(1));
         job.ya     = row_ff - Y_W'(1);
         job.emit_b = end_row && (row_ff != '0);
         job.xb     = X_W'(col_ff);
         job.yb     = row_ff - Y_W'(1);
         job.pix    = req.pixel_in;
      end else begin
         job.emit_b = 1'b1;
         job.xb     = X_W'(flush_ff);
         job.yb     = row_ff;
         job.fe     = last_flush;
      end
   end

   // raster position and flush sequencing
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      flush_in    = flush_ff;
      flushing_in = flushing_ff;
      if (take_pix) begin
         if (end_row) begin
            col_in = '0;
            if (row_ff >= hlast) begin
               flushing_in = 1'b1;
               flush_in    = '0;
            end else begin
               row_in = row_ff + Y_W'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end else if (take_flush) begin
         if (last_flush) begin
            flushing_in = 1'b0;
            flush_in    = '0;
            row_in      = '0;
            col_in      = '0;
         end else begin
            flush_in = flush_ff + CW'(1);
         end
      end
   end

   // register writes
   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  fw_in = csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: fh_in = csr_wdata[FH_W-1:0];
            default:          fw_in = fw_ff;
         endcase
      end
   end

   // stage that waits for the line store read
   assign f1_valid_in = take_pix || take_flush;
   assign f1_job_in   = job;
   assign f1_addr_in  = col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         flush_ff    <= '0;
         flushing_ff <= 1'b0;
         fw_ff       <= RST_FRAME_WIDTH;
         fh_ff       <= RST_FRAME_HEIGHT;
         f1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         flush_ff    <= flush_in;
         flushing_ff <= flushing_in;
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f1_job_ff  <= f1_job_in;
      f1_addr_ff <= f1_addr_in;
   end

   // line store: upper byte two rows back, lower byte one row back
   assign ram_we    = f1_valid_ff && f1_job_ff.is_pix;
   assign ram_wdata = {ram_rdata[PIX_W-1:0], f1_job_ff.pix};

   mf3_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (f1_addr_ff),
      .wdata (ram_wdata),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   // hand the word to the queue with its column from the line store
   always_comb begin
      push_job        = f1_job_ff;
      push_job.line_a = ram_rdata[2*PIX_W-1:PIX_W];
      push_job.line_b = ram_rdata[PIX_W-1:0];
   end
   assign push_valid = f1_valid_ff;

`ifndef SYNTHESIS
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      f1_valid_ff |-> (32'(level) < QUEUE_DEPTH))
      else $error("queue overflow on push");

   a_pixel_in_flush: assert property (@(posedge clock) disable iff (reset)
      (take && (req.action == ACT_PIXEL) && flushing_ff) |=> !f1_valid_ff)
      else $error("pixel taken during bottom row flush");
`endif

endmodule

// File: rtl/mf3_back.sv
module mf3_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  mf3_pkg::job_type pop_job,
   mf3_rsp_if.source        rsp
);
   import mf3_pkg::*;

   logic [8:0][PIX_W-1:0] win_ff, win_in;
   logic                  b0_valid_ff, b0_valid_in;
   job_type               b0_job_ff, b0_job_in;
   logic                  b1_valid_ff, b1_valid_in;
   job_type               b1_job_ff, b1_job_in;
   logic [2:0][2:0][PIX_W-1:0] b1_rows_ff, b1_rows_in;
   logic                  b2_valid_ff, b2_valid_in;
   job_type               b2_job_ff, b2_job_in;
   pix3_type              b2_cand_ff, b2_cand_in;
   logic                  pa_ff, pa_in;
   logic                  pb_ff, pb_in;
   logic                  rv_ff, rv_in;
   logic [X_W-1:0]        rx_ff, rx_in;
   logic [Y_W-1:0]        ry_ff, ry_in;
   pix_type               rval_ff, rval_in;
   logic                  rfe_ff, rfe_in;
   logic                  out_free, send_a, send_b;
   logic                  b2_free, b1_free, b0_free, take;

   // stage enables, the output side sets the pace
   always_comb begin
      out_free  = !rv_ff || rsp.ready;
      send_a    = b2_valid_ff && pa_ff && out_free;
      send_b    = b2_valid_ff && !pa_ff && pb_ff && out_free;
      b2_free   = !b2_valid_ff || (!pa_ff && !pb_ff) || (out_free && !(pa_ff && pb_ff));
      b1_free   = !b1_valid_ff || b2_free;
      b0_free   = !b0_valid_ff || b1_free;
      pop_ready = b0_free;
      take      = pop_valid && b0_free;
   end

   // window shift on each pixel word
   always_comb begin
      win_in = win_ff;
      if (take && pop_job.is_pix) begin
         for (int k = 0; k < 3; k++) begin
            win_in[3*k]   = win_ff[3*k+1];
            win_in[3*k+1] = win_ff[3*k+2];
         end
         win_in[2] = pop_job.line_a;
         win_in[5] = pop_job.line_b;
         win_in[8] = pop_job.pix;
      end
   end

   // stage 0 holds the word whose window is current
   always_comb begin
      b0_valid_in = b0_free ? pop_valid : b0_valid_ff;
      b0_job_in   = take ? pop_job : b0_job_ff;
   end

   // stage 1: sort each window row
   always_comb begin
      b1_valid_in = b1_free ? b0_valid_ff : b1_valid_ff;
      b1_job_in   = b1_free ? b0_job_ff : b1_job_ff;
      b1_rows_in  = b1_rows_ff;
      if (b1_free) begin
         for (int k = 0; k < 3; k++) begin
            b1_rows_in[k] = sort3(win_ff[3*k], win_ff[3*k+1], win_ff[3*k+2]);
         end
      end
   end

   // stage 2: max of lows, median of middles, min of highs
   always_comb begin
      b2_valid_in = b2_free ? b1_valid_ff : b2_valid_ff;
      b2_job_in   = b2_free ? b1_job_ff : b2_job_ff;
      b2_cand_in  = b2_cand_ff;
      pa_in       = pa_ff && !send_a;
      pb_in       = pb_ff && !send_b;
      if (b2_free) begin
         b2_cand_in[0] = max3(b1_rows_ff[0][0], b1_rows_ff[1][0], b1_rows_ff[2][0]);
         b2_cand_in[1] = med3(b1_rows_ff[0][1], b1_rows_ff[1][1], b1_rows_ff[2][1]);
         b2_cand_in[2] = min3(b1_rows_ff[0][2], b1_rows_ff[1][2], b1_rows_ff[2][2]);
         pa_in         = b1_valid_ff && b1_job_ff.emit_a;
         pb_in         = b1_valid_ff && b1_job_ff.emit_b;
      end
   end

   // output register, one result word per cycle while the receiver is ready
   always_comb begin
      rv_in   = out_free ? (send_a || send_b) : rv_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      rval_in = rval_ff;
      rfe_in  = rfe_ff;
      if (send_a) begin
         rx_in   = b2_job_ff.xa;
         ry_in   = b2_job_ff.ya;
         rval_in = b2_job_ff.med_a ? med3(b2_cand_ff[0], b2_cand_ff[1], b2_cand_ff[2]) : '0;
         rfe_in  = 1'b0;
      end else if (send_b) begin
         rx_in   = b2_job_ff.xb;
         ry_in   = b2_job_ff.yb;
         rval_in = '0;
         rfe_in  = b2_job_ff.fe;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         pa_ff       <= 1'b0;
         pb_ff       <= 1'b0;
         rv_ff       <= 1'b0;
      end else begin
         b0_valid_ff <= b0_valid_in;
         b1_valid_ff <= b1_valid_in;
         b2_valid_ff <= b2_valid_in;
         pa_ff       <= pa_in;
         pb_ff       <= pb_in;
         rv_ff       <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff     <= win_in;
      b0_job_ff  <= b0_job_in;
      b1_job_ff  <= b1_job_in;
      b1_rows_ff <= b1_rows_in;
      b2_job_ff  <= b2_job_in;
      b2_cand_ff <= b2_cand_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      rval_ff    <= rval_in;
      rfe_ff     <= rfe_in;
   end

   assign rsp.valid     = rv_ff;
   assign rsp.out_x     = rx_ff;
   assign rsp.out_y     = ry_ff;
   assign rsp.out_value = rval_ff;
   assign rsp.frame_end = rfe_ff;

`ifndef SYNTHESIS
   a_second_kept: assert property (@(posedge clock) disable iff (reset)
      (b2_valid_ff && pa_ff && pb_ff) |=> (b2_valid_ff && pb_ff))
      else $error("row border word dropped");

   a_flush_no_shift: assert property (@(posedge clock) disable iff (reset)
      (take && !pop_job.is_pix) |=> $stable(win_ff))
      else $error("window moved on a flush word");

   a_end_is_border: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rfe_ff) |-> (rval_ff == '0))
      else $error("frame end word not on the border");
`endif

endmodule

// File: rtl/median_filter_3x3.sv
// 3x3 median filter for a raster stream of 8-bit grey pixels.
// req_chan carries one word per pixel (action = pixel) in raster order, then
// flush words (action = flush) that drain the bottom border row. rsp_chan
// returns filtered pixels tagged with their column and row; border pixels are
// 0 and frame_end marks the last word of the frame. Pixel (x,y) comes out once
// pixel (x+1,y+1) is taken; the last pixel of a row also releases the right
// border pixel of the row above. Pixels sent during the flush and flush words
// sent outside it are taken and dropped.
// Frame size is set through csr_we/csr_index/csr_wdata while no word is in
// flight; values are saturated to 3..MAX_WIDTH columns and 3..4096 rows.
// A result word passes the front stage, the queue, back stages 0 to 2 and the
// output register before it shows on rsp_chan.
// One word is taken per cycle while req_chan.ready is high; the single-port
// write line store and the one-result-per-cycle output register set this, so
// a row-ending pixel, which gives two results, holds back the word behind it.
// A stalled receiver holds the output register, the back pipeline fills, then
// the queue, and req_chan.ready drops. Reset returns to column 0, row 0 with
// the default 640x480 frame; the line store needs no clearing.
module median_filter_3x3 #(
   parameter int MAX_WIDTH   = mf3_pkg::DEF_MAX_WIDTH,
   parameter int QUEUE_DEPTH = mf3_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mf3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mf3_pkg::CSR_W-1:0]     csr_wdata,
   mf3_req_if.sink                       req_chan,
   mf3_rsp_if.source                     rsp_chan
);
   import mf3_pkg::*;

   localparam int LW = $clog2(QUEUE_DEPTH + 1);

   logic          push_valid;
   job_type       push_job;
   logic          pop_valid;
   logic          pop_ready;
   job_type       pop_job;
   logic [LW-1:0] level;

   // classify words and run the line store
   mf3_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req        (req_chan),
      .level      (level),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // decouple front from back
   mf3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .level      (level)
   );

   // window, median network and result output
   mf3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp       (rsp_chan)
   );

endmodule
